// ===== rtl/gcsa_pkg.sv =====
package gcsa_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IndexBits    = 16;
  localparam int unsigned SumW         = 48;
  localparam int unsigned CountW       = 32;
  localparam logic [31:0] MissingReset = 32'd25599744;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_FINAL = 2'd1,
    OP_COUNT = 2'd2,
    OP_DUMP  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_MERGED  = 3'd1,
    ST_MISSING = 3'd2,
    ST_FULL    = 3'd3,
    ST_DONE    = 3'd4,
    ST_ENTRY   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    REG_MISSING = 3'd0,
    REG_I_LOW   = 3'd1,
    REG_I_HIGH  = 3'd2,
    REG_J_LOW   = 3'd3,
    REG_J_HIGH  = 3'd4
  } reg_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        cell_i;
    logic [15:0]        cell_j;
    logic signed [31:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [6:0]         match_count;
    logic [15:0]        out_i;
    logic [15:0]        out_j;
    logic signed [47:0] out_value;
    logic               out_hit;
    logic               last;
  } out_beat_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ===== rtl/gcsa_div.sv =====
// restoring divider, one quotient bit per cycle, truncates toward zero
module gcsa_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [gcsa_pkg::SumW-1:0]     dividend_i,
  input  logic [gcsa_pkg::CountW-1:0]          divisor_i,
  output gcsa_pkg::div_ctl_t                   ctl_o,
  output logic signed [gcsa_pkg::SumW-1:0]     quot_o
);
  localparam int unsigned W  = gcsa_pkg::SumW;
  localparam int unsigned CW = gcsa_pkg::CountW;
  localparam int unsigned NW = $clog2(W + 1);

  logic [W-1:0]  q_q, q_d;
  logic [CW:0]   r_q, r_d;
  logic [CW-1:0] dv_q, dv_d;
  logic          neg_q, neg_d;
  logic [NW-1:0] n_q, n_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [CW:0]   sh;
  logic [CW:0]   diff;

  always_comb begin
    q_d = q_q; r_d = r_q; dv_d = dv_q; neg_d = neg_q; n_d = n_q;
    busy_d = busy_q; done_d = 1'b0;
    sh   = {r_q[CW-1:0], q_q[W-1]};
    diff = sh - {1'b0, dv_q};
    if (start_i) begin
      neg_d  = dividend_i[W-1];
      q_d    = dividend_i[W-1] ? W'(-dividend_i) : W'(dividend_i);
      r_d    = '0;
      dv_d   = divisor_i;
      n_d    = NW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[CW]) begin
        r_d = diff;
        q_d = {q_q[W-2:0], 1'b1};
      end else begin
        r_d = sh;
        q_d = {q_q[W-2:0], 1'b0};
      end
      n_d = n_q - 1'b1;
      if (n_q == NW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      n_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      n_q    <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; dv_q <= dv_d; neg_q <= neg_d;
  end

  assign quot_o = neg_q ? -$signed(q_q) : $signed(q_q);
  assign ctl_o  = '{start: start_i, busy: busy_q, done: done_q};

endmodule

// ===== rtl/grid_cell_sample_accumulator_unit.sv =====
// channel | dir | handshake               | payload
// in      | in  | in_valid_i/in_stall_o   | gcsa_pkg::in_beat_t
// out     | out | out_valid_o/out_stall_i | gcsa_pkg::out_beat_t
// cfg     | in  | apb psel/penable        | 32-bit registers at 4*i
// an item walks the used entries through one read port, a read and a check per entry:
// add stops at a matching key and count walks every entry, then both pass a write state,
// dump adds an emit state per matching entry and a flush state to close, plus stalls,
// finalize runs the serial divider for each entry with a nonzero count.
// reset empties the table (fill count to zero), no clearing pass.
// a result waits in the output register; a stalled beat holds the scan.
module grid_cell_sample_accumulator_unit #(
  parameter int unsigned TABLE_ENTRIES = gcsa_pkg::TableEntries,
  parameter int unsigned INDEX_BITS    = gcsa_pkg::IndexBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gcsa_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gcsa_pkg::out_beat_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SW = gcsa_pkg::SumW;
  localparam int unsigned CW = gcsa_pkg::CountW;
  localparam logic signed [SW-1:0] SumMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SumMin = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic [INDEX_BITS-1:0] ei;
    logic [INDEX_BITS-1:0] ej;
    logic signed [SW-1:0]  sum;
    logic [CW-1:0]         cnt;
  } entry_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_EMIT  = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_e;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_q;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  entry_t        wdata;

  state_e state_q, state_d;
  logic [FW-1:0] used_q, used_d, k_q, k_d;
  logic [6:0]    cnt_q, cnt_d;
  logic          any_q, any_d;
  entry_t        hd_q, hd_d;
  gcsa_pkg::in_beat_t item_q;
  logic          item_en;
  logic          ov_q, ov_d;
  gcsa_pkg::out_beat_t ob_q, ob_d;

  logic [31:0] miss_q;
  logic [15:0] ilo_q, ihi_q, jlo_q, jhi_q;

  gcsa_pkg::div_ctl_t div_ctl;
  logic signed [SW-1:0] quot;

  // config
  logic cfg_wr;
  gcsa_pkg::reg_e reg_sel;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = gcsa_pkg::reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q <= gcsa_pkg::MissingReset;
      ilo_q  <= '0;
      ihi_q  <= 16'hffff;
      jlo_q  <= '0;
      jhi_q  <= 16'hffff;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (reg_sel)
        gcsa_pkg::REG_MISSING: miss_q <= pwdata;
        gcsa_pkg::REG_I_LOW:   ilo_q  <= pwdata[15:0];
        gcsa_pkg::REG_I_HIGH:  ihi_q  <= pwdata[15:0];
        gcsa_pkg::REG_J_LOW:   jlo_q  <= pwdata[15:0];
        gcsa_pkg::REG_J_HIGH:  jhi_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (reg_sel)
        gcsa_pkg::REG_MISSING: prdata = miss_q;
        gcsa_pkg::REG_I_LOW:   prdata = {16'h0, ilo_q};
        gcsa_pkg::REG_I_HIGH:  prdata = {16'h0, ihi_q};
        gcsa_pkg::REG_J_LOW:   prdata = {16'h0, jlo_q};
        gcsa_pkg::REG_J_HIGH:  prdata = {16'h0, jhi_q};
        default:               prdata = '0;
      endcase
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  gcsa_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == S_CHECK && gcsa_pkg::op_e'(item_q.op) == gcsa_pkg::OP_FINAL
                && rd_q.cnt != '0),
    .dividend_i(rd_q.sum),
    .divisor_i (rd_q.cnt),
    .ctl_o     (div_ctl),
    .quot_o    (quot)
  );

  logic [INDEX_BITS-1:0] ci, cj;
  logic                  hit_key, in_rect, k_end;
  logic [SW:0]           add_w;
  logic signed [SW-1:0]  add_sat;
  logic [15:0]           ri, rj;

  assign ci = INDEX_BITS'(in_data_i.cell_i & 16'((64'd1 << INDEX_BITS) - 1));
  assign cj = INDEX_BITS'(in_data_i.cell_j & 16'((64'd1 << INDEX_BITS) - 1));
  assign ri = 16'(rd_q.ei);
  assign rj = 16'(rd_q.ej);
  assign hit_key = rd_q.ei == INDEX_BITS'(item_q.cell_i) && rd_q.ej == INDEX_BITS'(item_q.cell_j);
  assign in_rect = ri >= ilo_q && ri <= ihi_q && rj >= jlo_q && rj <= jhi_q;
  assign add_w   = {rd_q.sum[SW-1], rd_q.sum} + (SW+1)'(item_q.sample);
  assign add_sat = (add_w[SW] != add_w[SW-1]) ? (add_w[SW] ? SumMin : SumMax)
                                              : add_w[SW-1:0];
  assign k_end   = (k_q + 1'b1) >= used_q;

  logic out_free;
  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = state_q != S_IDLE || !out_free;
  assign item_en    = in_valid_i && !in_stall_o;

  function automatic gcsa_pkg::out_beat_t mk(gcsa_pkg::status_e st, logic [6:0] c);
    gcsa_pkg::out_beat_t b;
    b = '0;
    b.status = st;
    b.match_count = c;
    b.last = 1'b1;
    return b;
  endfunction

  function automatic gcsa_pkg::out_beat_t mk_entry(entry_t e, logic lst);
    gcsa_pkg::out_beat_t b;
    b = '0;
    b.status = gcsa_pkg::ST_ENTRY;
    b.out_i = 16'(e.ei);
    b.out_j = 16'(e.ej);
    b.out_value = e.sum;
    b.out_hit = 1'b1;
    b.last = lst;
    return b;
  endfunction

  always_comb begin
    state_d = state_q; used_d = used_q; k_d = k_q; cnt_d = cnt_q; any_d = any_q;
    hd_d = hd_q;
    ov_d = ov_q && out_stall_i; ob_d = ob_q;
    raddr = AW'(k_q); waddr = AW'(k_q); we = 1'b0; wdata = rd_q;
    unique case (state_q)
      S_IDLE: begin
        raddr = '0;
        if (item_en) begin
          k_d = '0; cnt_d = '0; any_d = 1'b0;
          if (gcsa_pkg::op_e'(in_data_i.op) == gcsa_pkg::OP_ADD
              && in_data_i.sample == miss_q) begin
            ov_d = 1'b1; ob_d = mk(gcsa_pkg::ST_MISSING, '0);
          end else if (used_q == '0) begin
            unique case (gcsa_pkg::op_e'(in_data_i.op))
              gcsa_pkg::OP_ADD: begin
                we = 1'b1; waddr = '0;
                wdata = '{ei: ci, ej: cj, sum: SW'(in_data_i.sample), cnt: CW'(1)};
                used_d = FW'(1);
                ov_d = 1'b1; ob_d = mk(gcsa_pkg::ST_NEW, '0);
              end
              default: begin
                ov_d = 1'b1; ob_d = mk(gcsa_pkg::ST_DONE, '0);
              end
            endcase
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_READ: state_d = S_CHECK;
      S_CHECK: begin
        unique case (gcsa_pkg::op_e'(item_q.op))
          gcsa_pkg::OP_ADD: begin
            if (hit_key) begin
              we = 1'b1;
              wdata.sum = add_sat;
              wdata.cnt = (rd_q.cnt == '1) ? rd_q.cnt : rd_q.cnt + 1'b1;
              ov_d = 1'b1; ob_d = mk(gcsa_pkg::ST_MERGED, '0);
              state_d = S_WRITE;
            end else if (k_end) begin
              if (used_q >= FW'(TABLE_ENTRIES)) begin
                ob_d = mk(gcsa_pkg::ST_FULL, '0);
              end else begin
                we = 1'b1; waddr = AW'(used_q);
                wdata = '{ei: INDEX_BITS'(item_q.cell_i), ej: INDEX_BITS'(item_q.cell_j),
                          sum: SW'(item_q.sample), cnt: CW'(1)};
                used_d = used_q + 1'b1;
                ob_d = mk(gcsa_pkg::ST_NEW, '0);
              end
              ov_d = 1'b1;
              state_d = S_WRITE;
            end else begin
              k_d = k_q + 1'b1; raddr = AW'(k_q + 1'b1); state_d = S_READ;
            end
          end
          gcsa_pkg::OP_FINAL: begin
            if (rd_q.cnt != '0) state_d = S_DIV;
            else begin
              we = 1'b1; wdata.cnt = CW'(1);
              state_d = S_EMIT;
            end
          end
          gcsa_pkg::OP_COUNT: begin
            if (k_end) begin
              ov_d = 1'b1;
              ob_d = mk(gcsa_pkg::ST_DONE, cnt_q + 7'(in_rect));
              state_d = S_WRITE;
            end else begin
              cnt_d = cnt_q + 7'(in_rect);
              k_d = k_q + 1'b1; raddr = AW'(k_q + 1'b1); state_d = S_READ;
            end
          end
          default: begin
            if (in_rect) begin
              state_d = S_EMIT;
            end else if (k_end) begin
              state_d = S_FLUSH;
            end else begin
              k_d = k_q + 1'b1; raddr = AW'(k_q + 1'b1); state_d = S_READ;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_ctl.done) begin
          we = 1'b1; wdata.sum = quot; wdata.cnt = CW'(1);
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // finalize step or dump beat, then next entry
        if (gcsa_pkg::op_e'(item_q.op) == gcsa_pkg::OP_DUMP) begin
          // a match is held back until the next one shows whether it is the last
          if (!any_q || out_free) begin
            if (any_q) begin
              ov_d = 1'b1;
              ob_d = mk_entry(hd_q, 1'b0);
            end
            hd_d = rd_q;
            any_d = 1'b1;
            if (k_end) state_d = S_FLUSH;
            else begin
              k_d = k_q + 1'b1; raddr = AW'(k_q + 1'b1); state_d = S_READ;
            end
          end
        end else if (k_end) begin
          if (out_free) begin
            ov_d = 1'b1; ob_d = mk(gcsa_pkg::ST_DONE, '0); state_d = S_WRITE;
          end
        end else begin
          k_d = k_q + 1'b1; raddr = AW'(k_q + 1'b1); state_d = S_READ;
        end
      end
      S_FLUSH: begin
        // held match goes out as the last beat, or done when nothing matched
        if (out_free) begin
          ov_d = 1'b1;
          ob_d = any_q ? mk_entry(hd_q, 1'b1) : mk(gcsa_pkg::ST_DONE, '0);
          state_d = S_IDLE;
        end
      end
      S_WRITE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
      any_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      any_q   <= any_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_en) item_q <= in_data_i;
    ob_q <= ob_d;
    hd_q <= hd_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = ob_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= FW'(TABLE_ENTRIES))
    else $error("fill count beyond table");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(ob_q))
    else $error("stalled result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_en |-> state_q == S_IDLE)
    else $error("item taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> !div_ctl.busy)
    else $error("divider restarted while busy");

endmodule
